FILE: rtl/defifo_pkg.sv
// package for the deadline expiring admission fifo
// holds field widths, operation and result codes, state encoding and the
// command and status structs shared by the controller and the datapath
package defifo_pkg;

   localparam int KIND_W         = 2;
   localparam int TIME_W         = 63;
   localparam int HANDLE_W       = 32;
   localparam int ENTRY_HANDLE_W = 31;
   localparam int FILL_W         = 5;

   localparam logic [KIND_W-1:0] KIND_PUSH      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE_ALL = 2'd2;

   localparam logic [KIND_W-1:0] RES_EXPIRED = 2'd0;
   localparam logic [KIND_W-1:0] RES_PUSH    = 2'd1;
   localparam logic [KIND_W-1:0] RES_POP     = 2'd2;
   localparam logic [KIND_W-1:0] RES_CLOSED  = 2'd3;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CHECK  = 9'b000000010,
      ST_PG_RD  = 9'b000000100,
      ST_PG_EV  = 9'b000001000,
      ST_PUSH   = 9'b000010000,
      ST_REJECT = 9'b000100000,
      ST_POP_EM = 9'b001000000,
      ST_CA_RD  = 9'b010000000,
      ST_CA_EM  = 9'b100000000
   } defifo_state_type;

   typedef struct packed {
      logic capture;
      logic rd_en;
      logic rd_head;
      logic start_purge;
      logic keep_step;
      logic drop_step;
      logic purge_end;
      logic push_emit;
      logic reject_emit;
      logic pop_emit;
      logic ca_emit;
      logic ca_end;
   } defifo_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              handle_neg;
      logic              occ_zero;
      logic              occ_one;
      logic              left_zero;
      logic              expired;
      logic              out_free;
   } defifo_status_type;

endpackage

FILE: rtl/defifo_ctrl.sv
// controller state machine of the deadline expiring admission fifo
// depends on defifo_pkg; drives commands to defifo_datapath from its status
module defifo_ctrl import defifo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  defifo_status_type status,
   output defifo_cmd_type    cmd
);

   defifo_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (status.kind)
               KIND_PUSH: begin
                  if (status.handle_neg) begin
                     state_in = ST_REJECT;
                  end else begin
                     cmd.start_purge = 1'b1;
                     state_in        = ST_PG_RD;
                  end
               end
               KIND_POP: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_head = 1'b1;
                  state_in    = ST_POP_EM;
               end
               KIND_CLOSE_ALL: begin
                  if (status.occ_zero) begin
                     cmd.ca_end = 1'b1;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_head = 1'b1;
                     state_in    = ST_CA_EM;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PG_RD: begin
            if (status.left_zero) begin
               cmd.purge_end = 1'b1;
               state_in      = ST_PUSH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_PG_EV;
            end
         end
         ST_PG_EV: begin
            if (!status.expired) begin
               cmd.keep_step = 1'b1;
               state_in      = ST_PG_RD;
            end else if (status.out_free) begin
               cmd.drop_step = 1'b1;
               state_in      = ST_PG_RD;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_REJECT: begin
            if (status.out_free) begin
               cmd.reject_emit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_POP_EM: begin
            if (status.out_free) begin
               cmd.pop_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CA_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_head = 1'b1;
            state_in    = ST_CA_EM;
         end
         ST_CA_EM: begin
            if (status.out_free) begin
               cmd.ca_emit = 1'b1;
               state_in    = status.occ_one ? ST_IDLE : ST_CA_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/defifo_datapath.sv
// datapath of the deadline expiring admission fifo: slot memory, ring
// pointers, purge walk counters and the result register
// depends on defifo_pkg; driven by defifo_ctrl
module defifo_datapath import defifo_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  defifo_cmd_type            cmd,
   output defifo_status_type         status,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic [TIME_W-1:0]         req_now_time,
   input  logic signed [HANDLE_W-1:0] req_client_handle,
   input  logic [TIME_W-1:0]         req_client_deadline,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [KIND_W-1:0]         rsp_result_kind,
   output logic                      rsp_ok,
   output logic [ENTRY_HANDLE_W-1:0] rsp_entry_handle,
   output logic [TIME_W-1:0]         rsp_entry_deadline,
   output logic [FILL_W-1:0]         rsp_fill_level,
   output logic                      rsp_last
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W = ENTRY_HANDLE_W + TIME_W;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [FILL_W-1:0] fill_out(input logic [OCC_W-1:0] occ);
      logic [OCC_W+FILL_W-1:0] wide;
      wide = {{FILL_W{1'b0}}, occ};
      return wide[FILL_W-1:0];
   endfunction

   logic [WORD_W-1:0] mem [QUEUE_DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   logic [KIND_W-1:0]   kind_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [TIME_W-1:0]   deadline_ff;

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [OCC_W-1:0] occ_ff, occ_in, left_ff, left_in, fill_ff, fill_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]         res_kind_ff, res_kind_in;
   logic                      res_ok_ff, res_ok_in;
   logic [ENTRY_HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [TIME_W-1:0]         res_deadline_ff, res_deadline_in;
   logic [FILL_W-1:0]         res_fill_ff, res_fill_in;
   logic                      res_last_ff, res_last_in;

   logic [ENTRY_HANDLE_W-1:0] rd_handle;
   logic [TIME_W-1:0]         rd_deadline;
   logic                      emit, full, out_free, mem_we;
   logic [IDX_W-1:0]          mem_waddr, raddr;
   logic [WORD_W-1:0]         mem_wdata;
   logic [OCC_W:0]            tail_sum;

   assign rd_handle   = rdata_ff[WORD_W-1:TIME_W];
   assign rd_deadline = rdata_ff[TIME_W-1:0];
   assign full        = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign raddr       = cmd.rd_head ? head_ff : rd_ff;
   assign tail_sum    = {1'b0, fill_ff} + (OCC_W + 1)'(head_ff);

   assign status.kind       = kind_ff;
   assign status.handle_neg = handle_ff[HANDLE_W-1];
   assign status.occ_zero   = (occ_ff == '0);
   assign status.occ_one    = (occ_ff == OCC_W'(1));
   assign status.left_zero  = (left_ff == '0);
   assign status.expired    = (now_ff == '0) || (now_ff >= rd_deadline);
   assign status.out_free   = out_free;

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         now_ff      <= req_now_time;
         handle_ff   <= req_client_handle;
         deadline_ff <= req_client_deadline;
      end
      if (emit) begin
         res_kind_ff     <= res_kind_in;
         res_ok_ff       <= res_ok_in;
         res_handle_ff   <= res_handle_in;
         res_deadline_ff <= res_deadline_in;
         res_fill_ff     <= res_fill_in;
         res_last_ff     <= res_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         left_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         left_ff      <= left_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      occ_in          = occ_ff;
      rd_in           = rd_ff;
      wr_in           = wr_ff;
      left_in         = left_ff;
      fill_in         = fill_ff;
      mem_we          = 1'b0;
      mem_waddr       = wr_ff;
      mem_wdata       = rdata_ff;
      emit            = 1'b0;
      res_kind_in     = RES_PUSH;
      res_ok_in       = 1'b0;
      res_handle_in   = '0;
      res_deadline_in = '0;
      res_fill_in     = fill_out(occ_ff);
      res_last_in     = 1'b1;

      if (cmd.start_purge) begin
         rd_in   = head_ff;
         wr_in   = head_ff;
         left_in = occ_ff;
         fill_in = occ_ff;
      end
      if (cmd.keep_step) begin
         mem_we  = 1'b1;
         wr_in   = wrap_inc(wr_ff);
         rd_in   = wrap_inc(rd_ff);
         left_in = left_ff - 1'b1;
      end
      if (cmd.drop_step) begin
         emit            = 1'b1;
         res_kind_in     = RES_EXPIRED;
         res_ok_in       = 1'b1;
         res_handle_in   = rd_handle;
         res_deadline_in = rd_deadline;
         res_fill_in     = fill_out(fill_ff - 1'b1);
         res_last_in     = 1'b0;
         fill_in         = fill_ff - 1'b1;
         rd_in           = wrap_inc(rd_ff);
         left_in         = left_ff - 1'b1;
      end
      if (cmd.purge_end) begin
         occ_in = fill_ff;
         if (tail_sum >= (OCC_W + 1)'(QUEUE_DEPTH)) begin
            tail_in = IDX_W'(tail_sum - (OCC_W + 1)'(QUEUE_DEPTH));
         end else begin
            tail_in = IDX_W'(tail_sum);
         end
      end
      if (cmd.push_emit) begin
         emit = 1'b1;
         if (!full) begin
            mem_we      = 1'b1;
            mem_waddr   = tail_ff;
            mem_wdata   = {handle_ff[ENTRY_HANDLE_W-1:0], deadline_ff};
            tail_in     = wrap_inc(tail_ff);
            occ_in      = occ_ff + 1'b1;
            res_ok_in   = 1'b1;
            res_fill_in = fill_out(occ_ff + 1'b1);
         end
      end
      if (cmd.reject_emit) begin
         emit = 1'b1;
      end
      if (cmd.pop_emit) begin
         emit        = 1'b1;
         res_kind_in = RES_POP;
         res_fill_in = '0;
         if (occ_ff != '0) begin
            res_ok_in       = 1'b1;
            res_handle_in   = rd_handle;
            res_deadline_in = rd_deadline;
            res_fill_in     = fill_out(occ_ff - 1'b1);
            head_in         = wrap_inc(head_ff);
            occ_in          = occ_ff - 1'b1;
         end
      end
      if (cmd.ca_emit) begin
         emit            = 1'b1;
         res_kind_in     = RES_CLOSED;
         res_ok_in       = 1'b1;
         res_handle_in   = rd_handle;
         res_deadline_in = rd_deadline;
         res_fill_in     = fill_out(occ_ff - 1'b1);
         res_last_in     = (occ_ff == OCC_W'(1));
         occ_in          = occ_ff - 1'b1;
         if (occ_ff == OCC_W'(1)) begin
            head_in = '0;
            tail_in = '0;
         end else begin
            head_in = wrap_inc(head_ff);
         end
      end
      if (cmd.ca_end) begin
         head_in = '0;
         tail_in = '0;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = res_kind_ff;
   assign rsp_ok             = res_ok_ff;
   assign rsp_entry_handle   = res_handle_ff;
   assign rsp_entry_deadline = res_deadline_ff;
   assign rsp_fill_level     = res_fill_ff;
   assign rsp_last           = res_last_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_purge_counts: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= left_ff)
      else $error("purge survivor count below unread count");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded while result register is stalled");

   a_wr_lags_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.keep_step && (wr_ff != rd_ff) |=> (wr_ff != rd_ff))
      else $error("compaction write pointer caught the read pointer");
`endif

endmodule

FILE: rtl/deadline_expiring_admission_fifo.sv
// deadline expiring admission fifo, top level
// requests are taken one at a time: req_ready is high only while the controller is idle, so a
// new request waits until the previous one has finished; a push first walks the held entries
// through the one read port to purge expired ones, and any result can stall on rsp_ready
// reset is synchronous, active high: pointers and occupancy clear at once, slots stay unset
// depends on defifo_pkg, defifo_ctrl and defifo_datapath
module deadline_expiring_admission_fifo import defifo_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [TIME_W-1:0]          req_now_time,
   input  logic signed [HANDLE_W-1:0] req_client_handle,
   input  logic [TIME_W-1:0]          req_client_deadline,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [KIND_W-1:0]          rsp_result_kind,
   output logic                       rsp_ok,
   output logic [ENTRY_HANDLE_W-1:0]  rsp_entry_handle,
   output logic [TIME_W-1:0]          rsp_entry_deadline,
   output logic [FILL_W-1:0]          rsp_fill_level,
   output logic                       rsp_last
);

   defifo_cmd_type    cmd;
   defifo_status_type status;

   defifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   defifo_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_now_time        (req_now_time),
      .req_client_handle   (req_client_handle),
      .req_client_deadline (req_client_deadline),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_ok              (rsp_ok),
      .rsp_entry_handle    (rsp_entry_handle),
      .rsp_entry_deadline  (rsp_entry_deadline),
      .rsp_fill_level      (rsp_fill_level),
      .rsp_last            (rsp_last)
   );

endmodule
